// ----- hdl/cbq_pkg.sv -----
// cbq_pkg: shared types and constants for the call button qualifier
// holds the per-button state record, the request record and the result record
// no dependencies
package cbq_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int BtnIdxW     = 4;
  localparam int TimerW      = 6;
  localparam int SlotW       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam logic [TimerW-1:0] TimerCap      = TimerW'(60);
  localparam logic [TimerW-1:0] RegisterTime  = TimerW'(10);
  localparam logic [TimerW-1:0] ReleaseStep   = TimerW'(2);
  localparam logic [TimerW-1:0] CancelTimeRst = TimerW'(30);

  typedef struct packed {
    logic [TimerW-1:0] timer;
    logic              hall;
    logic              last;
    logic              armed;
    logic              cancel;
    logic              first;
  } btn_state_t;

  typedef struct packed {
    logic pressed;
    logic cabin_call;
    logic clear_all;
    logic force_all_set;
    logic hall_set_req;
    logic hall_clear_req;
    logic cabin_clear_pending;
    logic blink_selected;
    logic blink_on;
  } btn_req_t;

  typedef struct packed {
    logic lamp;
    logic hall_call;
    logic cancel_request;
    logic first_cabin;
    logic still_on;
    logic cabin_clear_request;
  } btn_res_t;

endpackage

// ----- hdl/cbq_update.sv -----
// cbq_update: combinational next-state and result logic for one button
// takes the stored state of one button and one scan tick's request flags
// depends on cbq_pkg
module cbq_update (
  input  cbq_pkg::btn_state_t          state_i,
  input  cbq_pkg::btn_req_t            req_i,
  input  logic [cbq_pkg::TimerW-1:0]   cancel_time_i,
  output cbq_pkg::btn_state_t          state_o,
  output cbq_pkg::btn_res_t            res_o
);
  import cbq_pkg::*;

  logic force_set;
  logic clr_all;
  logic hset;
  logic hclr;
  logic cclr;
  logic hclr_left;
  logic cclr_left;
  logic still;
  logic cc_req;
  btn_state_t st;

  assign force_set = req_i.force_all_set;
  assign clr_all   = req_i.clear_all && !force_set;
  assign hset      = req_i.hall_set_req || force_set;
  assign hclr      = req_i.hall_clear_req && !force_set;
  assign cclr      = req_i.cabin_clear_pending && !force_set;

  always_comb begin
    st        = state_i;
    still     = 1'b0;
    cc_req    = 1'b0;
    hclr_left = 1'b0;
    cclr_left = 1'b0;

    // pending requests first
    if (clr_all) begin
      if (st.hall) begin
        still   = 1'b1;
        st.hall = 1'b0;
      end
      if (req_i.cabin_call) begin
        still  = 1'b1;
        cc_req = 1'b1;
      end
      hclr_left = hclr;
      cclr_left = cclr || req_i.cabin_call;
    end else begin
      if (hclr) begin
        st.hall = 1'b0;
      end else if (hset) begin
        st.hall   = 1'b1;
        st.cancel = 1'b0;
        st.armed  = 1'b0;
      end
      cclr_left = cclr && req_i.cabin_call;
    end

    // cabin-originated call
    if (req_i.cabin_call && !st.hall && !hclr_left && !cclr_left) begin
      st.first  = 1'b1;
      st.hall   = 1'b1;
      st.cancel = 1'b0;
    end
    if (!st.hall && !req_i.cabin_call) begin
      st.first = 1'b0;
    end
    if (!st.hall) begin
      st.cancel = 1'b0;
      st.armed  = 1'b0;
    end

    // press timer
    if (req_i.pressed) begin
      if (st.timer < TimerCap) begin
        st.timer = st.timer + TimerW'(1);
      end
      if (!st.hall && !st.last) begin
        if (st.timer > RegisterTime) begin
          st.hall = 1'b1;
          st.last = 1'b1;
        end
      end else if (!st.cancel && st.hall && st.armed) begin
        if (st.timer > cancel_time_i) begin
          st.cancel = 1'b1;
        end
      end
    end else begin
      if (st.timer > TimerW'(1)) begin
        st.timer = st.timer - ReleaseStep;
      end else begin
        if (st.hall) begin
          st.armed = 1'b1;
        end
        st.last = st.hall;
      end
    end
  end

  assign state_o = st;

  assign res_o.lamp                = st.hall && (!req_i.blink_selected || req_i.blink_on);
  assign res_o.hall_call           = st.hall;
  assign res_o.cancel_request      = st.cancel;
  assign res_o.first_cabin         = st.first;
  assign res_o.still_on            = still;
  assign res_o.cabin_clear_request = cc_req;

endmodule

// ----- hdl/call_button_qualifier_unit.sv -----
// call_button_qualifier_unit: top level of the hall call button qualifier
// holds per-button state, the input register and the result register
// depends on cbq_pkg and cbq_update
//
// usage:
//   input channel (in_valid_i / in_ready_o): one beat is one scan tick for the
//   button named by button_index_i, with its contact level and request flags
//   output channel (out_valid_o / out_ready_i): one result beat per input beat,
//   in order: lamp, hall call, cancel request, first cabin, still on, cabin clear
//   config channel (cfg_valid_i / cfg_ready_o): writes cancel_press_time, always
//   ready; write it only while no beat is in flight
// latency: result valid one cycle after the input accept edge (input register,
//   then the state update and result register in one cycle)
// throughput: one beat per cycle, set by the single-cycle read-modify-write of
//   the per-button state flops; back-to-back beats on one button are safe
//   because the state is written at the same edge the result is registered
// reset: all button state clears to zero, cancel_press_time returns to 30,
//   both stages empty
// stall: with out_ready_i low the result register holds; one more beat can sit
//   in the input register, after which in_ready_o drops
// a button index at or beyond the button count gives an all-zero result
module call_button_qualifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbq_pkg::TimerW-1:0]  cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cbq_pkg::BtnIdxW-1:0] button_index_i,
  input  logic                        pressed_i,
  input  logic                        cabin_call_i,
  input  logic                        clear_all_i,
  input  logic                        force_all_set_i,
  input  logic                        hall_set_req_i,
  input  logic                        hall_clear_req_i,
  input  logic                        cabin_clear_pending_i,
  input  logic                        blink_selected_i,
  input  logic                        blink_on_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        lamp_o,
  output logic                        hall_call_o,
  output logic                        cancel_request_o,
  output logic                        first_cabin_o,
  output logic                        still_on_o,
  output logic                        cabin_clear_request_o
);
  import cbq_pkg::*;

  logic [TimerW-1:0]  cancel_time_q;

  logic               s1_valid_q;
  logic [BtnIdxW-1:0] s1_idx_q;
  btn_req_t           s1_req_q;

  logic               out_valid_q;
  btn_res_t           res_q;

  btn_state_t         state_q [NUM_BUTTONS];

  logic               s1_adv;
  logic               in_range;
  logic [SlotW-1:0]   slot;
  btn_state_t         cur_state;
  btn_state_t         nxt_state;
  btn_res_t           nxt_res;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_range   = 32'(s1_idx_q) < NUM_BUTTONS;
  assign slot       = SlotW'(s1_idx_q);
  assign cur_state  = state_q[slot];

  cbq_update u_update (
    .state_i       (cur_state),
    .req_i         (s1_req_q),
    .cancel_time_i (cancel_time_q),
    .state_o       (nxt_state),
    .res_o         (nxt_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cancel_time_q <= CancelTimeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cancel_time_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_idx_q                     <= button_index_i;
      s1_req_q.pressed             <= pressed_i;
      s1_req_q.cabin_call          <= cabin_call_i;
      s1_req_q.clear_all           <= clear_all_i;
      s1_req_q.force_all_set       <= force_all_set_i;
      s1_req_q.hall_set_req        <= hall_set_req_i;
      s1_req_q.hall_clear_req      <= hall_clear_req_i;
      s1_req_q.cabin_clear_pending <= cabin_clear_pending_i;
      s1_req_q.blink_selected      <= blink_selected_i;
      s1_req_q.blink_on            <= blink_on_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        state_q[i] <= '0;
      end
    end else if (s1_adv && in_range) begin
      state_q[slot] <= nxt_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= in_range ? nxt_res : '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign lamp_o                = res_q.lamp;
  assign hall_call_o           = res_q.hall_call;
  assign cancel_request_o      = res_q.cancel_request;
  assign first_cabin_o         = res_q.first_cabin;
  assign still_on_o            = res_q.still_on;
  assign cabin_clear_request_o = res_q.cabin_clear_request;

  a_timer_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (cur_state.timer <= TimerCap))
    else $error("press timer above cap");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced beat did not reach the result register");

  a_cancel_needs_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && in_range) |-> (!nxt_state.cancel || nxt_state.hall))
    else $error("cancel flag set without a hall call");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s1_valid_q) |-> !in_ready_o)
    else $error("input taken while both stages are stalled");

endmodule
